FILE: rtl/core/sstf_pkg.sv
// Shared constants and types of the SSTF disk request scheduler.
package sstf_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int SECTOR_BITS_DEF = 48;

	localparam int THR_W = 7;
	localparam int WAIT_W = 8;
	localparam int AGE_W = 9;
	localparam int SEEK_W = 64;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [AGE_W-1:0] AGE_MAX = 9'd511;
	localparam logic [THR_W-1:0] THR_RESET = 7'd64;
	localparam logic [WAIT_W-1:0] WAIT_RESET = 8'd50;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_TICK = 2'd1,
		OP_DISPATCH = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BATCH_THRESHOLD = 1'd0,
		REG_MAX_WAIT = 1'd1
	} reg_idx_t;

	localparam logic [1:0] DIR_PARKED = 2'd0;
	localparam logic [1:0] DIR_LEFT = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;

	localparam logic KIND_DISPATCH = 1'b0;
	localparam logic KIND_REJECT = 1'b1;

	typedef struct packed {
		logic cand_vld;
		logic cand_first;
	} seek_ctl_t;

endpackage

FILE: rtl/core/sstf_ifs.sv
// Request and response channel interfaces of the SSTF scheduler.
interface sstf_req_if #(parameter int SECTOR_BITS = 48);
	logic valid;
	logic ready;
	logic [1:0] op;
	logic [SECTOR_BITS-1:0] sector;
	logic is_write;
	logic force_req;

	modport source (output valid, op, sector, is_write, force_req, input ready);
	modport sink (input valid, op, sector, is_write, force_req, output ready);
endinterface

interface sstf_rsp_if #(parameter int SECTOR_BITS = 48);
	logic valid;
	logic ready;
	logic kind;
	logic [SECTOR_BITS-1:0] out_sector;
	logic out_write;
	logic [1:0] head_direction;
	logic [63:0] seek_sum;
	logic last;

	modport source (output valid, kind, out_sector, out_write, head_direction, seek_sum, last,
		input ready);
	modport sink (input valid, kind, out_sector, out_write, head_direction, seek_sum, last,
		output ready);
endinterface

FILE: rtl/core/sstf_disk_request_scheduler_unit.sv
// An add or a non-flushing tick is handled in ST_IDLE; a flush pass runs ST_SCAN, ST_DRAIN and ST_EMIT in that order.
// A flush of N entries gives N results, one per pass, and each result waits in ST_EMIT until it is taken.
// Throughput: one transaction at a time; the single RAM read port scans one entry per cycle.
// Reset: arst_n clears count, age, head, direction, seek total and configuration.
// The request store is not cleared; only entries below the count are ever read.
// Top level of the SSTF disk request scheduler.
module sstf_disk_request_scheduler_unit import sstf_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int SECTOR_BITS = SECTOR_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	sstf_req_if.sink              req,
	sstf_rsp_if.source            rsp
);
	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;
	localparam int ENT_W = SECTOR_BITS + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       count_q;
	logic [AGE_W-1:0]       age_q;
	logic [THR_W-1:0]       thr_q;
	logic [WAIT_W-1:0]      maxw_q;
	logic                   head_known_q;
	logic [SECTOR_BITS-1:0] head_q;
	logic [1:0]             dir_q;
	logic [SEEK_W-1:0]      seek_q;
	logic [IDX_W-1:0]       rd_idx_q;
	logic [CNT_W-1:0]       pass_cnt_q;
	logic [IDX_W-1:0]       rm_idx_q;
	logic                   rm_vld_q;
	logic [IDX_W-1:0]       wr_ptr_q;
	logic                   vld_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic                   out_vld_q;
	logic                   kind_q;
	logic [SECTOR_BITS-1:0] osec_q;
	logic                   owr_q;
	logic                   last_q;

	logic                   req_fire;
	logic                   full;
	logic [AGE_W-1:0]       age_inc;
	logic                   tick_flush;
	logic                   disp_flush;
	logic                   keep;
	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;
	logic [ENT_W-1:0]       ram_wdata;
	logic [ENT_W-1:0]       ram_rdata;
	seek_ctl_t              seek_ctl;
	logic                   seek_busy;
	logic [SECTOR_BITS-1:0] best_dist;
	logic [SECTOR_BITS-1:0] best_sector;
	logic                   best_write;
	logic [IDX_W-1:0]       best_idx;
	op_t                    op;

	assign op = op_t'(req.op);
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire = req.valid && req.ready;
	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign age_inc = (age_q == AGE_MAX) ? age_q : age_q + AGE_W'(1);
	assign tick_flush = (count_q != '0) && (age_inc > AGE_W'(maxw_q));
	assign disp_flush = (count_q != '0) && (req.force_req
		|| (CMP_W'(count_q) >= CMP_W'(thr_q)) || (age_q > AGE_W'(maxw_q)));

	assign keep = vld_s1 && !(rm_vld_q && (idx_s1 == rm_idx_q));
	assign ram_we = keep || (req_fire && (op == OP_ADD) && !full);
	assign ram_waddr = keep ? wr_ptr_q : IDX_W'(count_q);
	assign ram_wdata = keep ? ram_rdata : {req.is_write, req.sector};

	assign seek_ctl.cand_vld = keep;
	assign seek_ctl.cand_first = (wr_ptr_q == '0);

	sstf_ram #(
		.WIDTH(ENT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (state_q == ST_SCAN),
		.raddr(rd_idx_q),
		.rdata(ram_rdata)
	);

	sstf_seek_unit #(
		.SECTOR_BITS(SECTOR_BITS),
		.IDX_W      (IDX_W)
	) u_seek (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (seek_ctl),
		.cand_idx   (wr_ptr_q),
		.cand_sector(ram_rdata[SECTOR_BITS-1:0]),
		.cand_write (ram_rdata[SECTOR_BITS]),
		.arm_pos    (head_q),
		.head_known (head_known_q),
		.busy       (seek_busy),
		.best_dist  (best_dist),
		.best_sector(best_sector),
		.best_write (best_write),
		.best_idx   (best_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			maxw_q <= WAIT_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_BATCH_THRESHOLD: thr_q <= cfg_wdata[THR_W-1:0];
				REG_MAX_WAIT: maxw_q <= cfg_wdata[WAIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			age_q <= '0;
			head_known_q <= 1'b0;
			head_q <= '0;
			dir_q <= DIR_PARKED;
			seek_q <= '0;
			rd_idx_q <= '0;
			pass_cnt_q <= '0;
			rm_idx_q <= '0;
			rm_vld_q <= 1'b0;
			wr_ptr_q <= '0;
			vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
			kind_q <= KIND_DISPATCH;
			osec_q <= '0;
			owr_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_SCAN);
			if (keep) begin
				wr_ptr_q <= wr_ptr_q + IDX_W'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						case (op)
							OP_ADD: begin
								if (full) begin
									kind_q <= KIND_REJECT;
									osec_q <= req.sector;
									owr_q <= req.is_write;
									last_q <= 1'b1;
									out_vld_q <= 1'b1;
									state_q <= ST_EMIT;
								end else begin
									if (count_q == '0) begin
										age_q <= '0;
									end
									count_q <= count_q + CNT_W'(1);
								end
							end
							OP_TICK: begin
								age_q <= age_inc;
								if (tick_flush) begin
									rd_idx_q <= '0;
									wr_ptr_q <= '0;
									pass_cnt_q <= count_q;
									rm_vld_q <= 1'b0;
									state_q <= ST_SCAN;
								end
							end
							OP_DISPATCH: begin
								if (disp_flush) begin
									rd_idx_q <= '0;
									wr_ptr_q <= '0;
									pass_cnt_q <= count_q;
									rm_vld_q <= 1'b0;
									state_q <= ST_SCAN;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (rd_idx_q == IDX_W'(pass_cnt_q - CNT_W'(1))) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					if (!vld_s1 && !seek_busy) begin
						if (head_known_q) begin
							seek_q <= seek_q + SEEK_W'(best_dist);
							dir_q <= (best_sector > head_q) ? DIR_RIGHT : DIR_LEFT;
						end
						head_q <= best_sector;
						head_known_q <= 1'b1;
						count_q <= count_q - CNT_W'(1);
						rm_idx_q <= best_idx;
						rm_vld_q <= 1'b1;
						kind_q <= KIND_DISPATCH;
						osec_q <= best_sector;
						owr_q <= best_write;
						last_q <= (count_q == CNT_W'(1));
						out_vld_q <= 1'b1;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (rsp.ready) begin
						out_vld_q <= 1'b0;
						if (last_q) begin
							state_q <= ST_IDLE;
						end else begin
							rd_idx_q <= '0;
							wr_ptr_q <= '0;
							pass_cnt_q <= count_q + CNT_W'(1);
							state_q <= ST_SCAN;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.kind = kind_q;
	assign rsp.out_sector = osec_q;
	assign rsp.out_write = owr_q;
	assign rsp.head_direction = dir_q;
	assign rsp.seek_sum = seek_q;
	assign rsp.last = last_q;
endmodule

FILE: rtl/core/sstf_ram.sv
// Generic simple dual-port RAM with registered read.
module sstf_ram #(
	parameter int WIDTH = 49,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

FILE: rtl/core/sstf_seek_unit.sv
// Distance unit: absolute seek distance and running nearest-entry selection.
module sstf_seek_unit import sstf_pkg::*; #(
	parameter int SECTOR_BITS = SECTOR_BITS_DEF,
	parameter int IDX_W = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  seek_ctl_t              ctl,
	input  logic [IDX_W-1:0]       cand_idx,
	input  logic [SECTOR_BITS-1:0] cand_sector,
	input  logic                   cand_write,
	input  logic [SECTOR_BITS-1:0] arm_pos,
	input  logic                   head_known,
	output logic                   busy,
	output logic [SECTOR_BITS-1:0] best_dist,
	output logic [SECTOR_BITS-1:0] best_sector,
	output logic                   best_write,
	output logic [IDX_W-1:0]       best_idx
);
	logic                   vld_s2;
	logic                   first_s2;
	logic [IDX_W-1:0]       idx_s2;
	logic [SECTOR_BITS-1:0] dist_s2;
	logic [SECTOR_BITS-1:0] sec_s2;
	logic                   wr_s2;
	logic [SECTOR_BITS-1:0] span;
	logic                   take;
	logic [SECTOR_BITS-1:0] best_dist_q;
	logic [SECTOR_BITS-1:0] best_sec_q;
	logic                   best_wr_q;
	logic [IDX_W-1:0]       best_idx_q;

	assign span = (cand_sector >= arm_pos) ? cand_sector - arm_pos : arm_pos - cand_sector;
	assign take = vld_s2 && (first_s2 || (head_known && (dist_s2 < best_dist_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= ctl.cand_vld;
		end
	end

	always_ff @(posedge clk) begin
		first_s2 <= ctl.cand_first;
		idx_s2 <= cand_idx;
		dist_s2 <= span;
		sec_s2 <= cand_sector;
		wr_s2 <= cand_write;
		if (take) begin
			best_dist_q <= dist_s2;
			best_sec_q <= sec_s2;
			best_wr_q <= wr_s2;
			best_idx_q <= idx_s2;
		end
	end

	assign busy = vld_s2;
	assign best_dist = best_dist_q;
	assign best_sector = best_sec_q;
	assign best_write = best_wr_q;
	assign best_idx = best_idx_q;
endmodule

FILE: rtl/core/sstf_checker.sv
// Port-level assertions for the SSTF scheduler and their bind to the top level.
module sstf_checker import sstf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic kind,
	input logic last
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is pending");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transaction");

	a_reject_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_REJECT) |-> last)
		else $error("reject not marked last");

	a_flush_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> !in_ready)
		else $error("input taken in the middle of a flush");
endmodule

bind sstf_disk_request_scheduler_unit sstf_checker u_sstf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (req.ready),
	.out_valid(rsp.valid),
	.out_ready(rsp.ready),
	.kind     (rsp.kind),
	.last     (rsp.last)
);

FILE: test/sstf_scheduler_checker.sv
`timescale 1ns / 100ps
// Scoreboard: predicts the SSTF scheduler's responses and checks every response transaction.
module sstf_scheduler_checker import sstf_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int SECTOR_BITS = SECTOR_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	sstf_req_if                   req,
	sstf_rsp_if                   rsp,
	output int                    pending,
	output int                    fail_count
);

	typedef struct packed {
		logic                   kind;
		logic [SECTOR_BITS-1:0] sector;
		logic                   wr;
		logic [1:0]             dir;
		logic [SEEK_W-1:0]      seek;
		logic                   last;
	} disp_t;

	disp_t                  due_q[$];
	logic [SECTOR_BITS-1:0] store_sec [QUEUE_DEPTH];
	logic                   store_wr [QUEUE_DEPTH];
	int                     held;
	logic                   head_valid;
	logic [SECTOR_BITS-1:0] arm_pos;
	logic [1:0]             arm_dir;
	logic [SEEK_W-1:0]      seek_acc;
	int                     age;
	logic [THR_W-1:0]       thr_reg;
	logic [WAIT_W-1:0]      wait_reg;
	int                     errs = 0;

	task automatic drain_nearest();
		int pick;
		logic [63:0] gap;
		logic [63:0] span;
		logic [SECTOR_BITS-1:0] sel;
		logic sel_wr;
		while (held > 0) begin
			pick = 0;
			if (head_valid) begin
				gap = '1;
				for (int i = 0; i < held; i++) begin
					span = (store_sec[i] >= arm_pos) ? 64'(store_sec[i] - arm_pos)
						: 64'(arm_pos - store_sec[i]);
					if (span < gap) begin
						gap = span;
						pick = i;
					end
				end
				sel = store_sec[pick];
				seek_acc += gap;
				arm_dir = (sel > arm_pos) ? DIR_RIGHT : DIR_LEFT;
			end else begin
				sel = store_sec[0];
			end
			sel_wr = store_wr[pick];
			arm_pos = sel;
			head_valid = 1'b1;
			for (int i = pick; i + 1 < held; i++) begin
				store_sec[i] = store_sec[i+1];
				store_wr[i] = store_wr[i+1];
			end
			held--;
			due_q.push_back('{kind: KIND_DISPATCH, sector: sel, wr: sel_wr, dir: arm_dir,
				seek: seek_acc, last: 1'(held == 0)});
		end
	endtask

	task automatic take_request();
		logic [SECTOR_BITS-1:0] sec;
		sec = req.sector;
		case (req.op)
			OP_ADD: begin
				if (held >= QUEUE_DEPTH) begin
					due_q.push_back('{kind: KIND_REJECT, sector: sec, wr: req.is_write,
						dir: arm_dir, seek: seek_acc, last: 1'b1});
				end else begin
					if (held == 0)
						age = 0;
					store_sec[held] = sec;
					store_wr[held] = req.is_write;
					held++;
				end
			end
			OP_TICK: begin
				if (age < AGE_MAX)
					age++;
				if (held > 0 && age > wait_reg)
					drain_nearest();
			end
			OP_DISPATCH: begin
				if (held > 0 && (req.force_req || held >= thr_reg || age > wait_reg))
					drain_nearest();
			end
			default: ;
		endcase
	endtask

	task automatic cmp_field(string what, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
			errs++;
		end
	endtask

	task automatic check_response();
		disp_t want;
		if (due_q.size() == 0) begin
			$display("%0t: response with nothing due, expected none, actual kind %0d sector %h",
				$time, rsp.kind, rsp.out_sector);
			errs++;
		end else begin
			want = due_q.pop_front();
			cmp_field("kind", want.kind, rsp.kind);
			cmp_field("out_sector", want.sector, rsp.out_sector);
			cmp_field("out_write", want.wr, rsp.out_write);
			cmp_field("head_direction", want.dir, rsp.head_direction);
			cmp_field("seek_sum", want.seek, rsp.seek_sum);
			cmp_field("last", want.last, rsp.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_q.delete();
			held = 0;
			head_valid = 1'b0;
			arm_pos = '0;
			arm_dir = DIR_PARKED;
			seek_acc = '0;
			age = 0;
			thr_reg = THR_RESET;
			wait_reg = WAIT_RESET;
			errs = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_idx))
					REG_BATCH_THRESHOLD: thr_reg = cfg_wdata[THR_W-1:0];
					REG_MAX_WAIT: wait_reg = cfg_wdata[WAIT_W-1:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready)
				take_request();
			if (rsp.valid && rsp.ready)
				check_response();
			pending <= due_q.size();
			fail_count <= errs;
		end
	end

endmodule

FILE: test/tb_sstf_disk_request_scheduler_unit.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, stimulus and verdict for the SSTF disk request scheduler.
module tb_sstf_disk_request_scheduler_unit import sstf_pkg::*; ();

	localparam int SB = SECTOR_BITS_DEF;
	localparam int DRAIN_CYCLES = QUEUE_DEPTH_DEF + 8;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 16;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [SB-1:0] SECTOR_TOP = '1;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	reg_idx_t              cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    req_idle_pct;
	int                    rsp_idle_pct;
	int                    hold_requests;
	int                    items_sent;
	int                    pending;
	int                    fail_count;
	logic [SB-1:0]         hot_base;

	int phase_thr [6] = '{1, 64, 0, 16, 64, 0};
	int phase_lim [6] = '{255, 1, 100, 10, 255, 0};

	sstf_req_if #(.SECTOR_BITS(SB)) req_ch ();
	sstf_rsp_if #(.SECTOR_BITS(SB)) rsp_ch ();

	sstf_disk_request_scheduler_unit #(
		.QUEUE_DEPTH(QUEUE_DEPTH_DEF),
		.SECTOR_BITS(SB)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	sstf_scheduler_checker #(
		.QUEUE_DEPTH(QUEUE_DEPTH_DEF),
		.SECTOR_BITS(SB)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.rsp(rsp_ch),
		.pending(pending),
		.fail_count(fail_count)
	);

	always #1 clk = ~clk;

	initial begin
		#50_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// hold off for a long stretch on request, otherwise take responses at random
	initial begin
		int hold_served;
		int hold_left;
		hold_served = 0;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
			end
		end
	end

	task automatic send(logic [1:0] op, logic [SB-1:0] sec, logic wr, logic frc);
		int gap;
		gap = ($urandom_range(99) < req_idle_pct) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.sector <= sec;
		req_ch.is_write <= wr;
		req_ch.force_req <= frc;
		do @(posedge clk); while (!req_ch.ready);
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(int thr, int lim);
		settle();
		cfg_we <= 1'b1;
		cfg_idx <= REG_BATCH_THRESHOLD;
		cfg_wdata <= CFG_DATA_W'(thr);
		@(posedge clk);
		cfg_idx <= REG_MAX_WAIT;
		cfg_wdata <= CFG_DATA_W'(lim);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [SB-1:0] pick_sector();
		case ($urandom_range(5))
			0, 1: return SB'({$urandom, $urandom});
			2, 3: return hot_base + SB'($urandom_range(24));
			4: return $urandom_range(1) ? SECTOR_TOP : '0;
			default: return hot_base;
		endcase
	endfunction

	task automatic random_burst();
		int pick;
		int n;
		pick = $urandom_range(99);
		if (pick < 55) begin
			hot_base = SB'({$urandom, $urandom});
			n = ($urandom_range(9) == 0) ? $urandom_range(40, 66) : $urandom_range(1, 10);
			repeat (n)
				send(OP_ADD, pick_sector(), 1'($urandom_range(1)),
					1'($urandom_range(1)));
			if ($urandom_range(1))
				send(OP_DISPATCH, pick_sector(), 1'($urandom_range(1)),
					1'($urandom_range(1)));
			else
				repeat ($urandom_range(1, 6))
					send(OP_TICK, pick_sector(), 1'($urandom_range(1)),
						1'($urandom_range(1)));
		end else if (pick < 75) begin
			repeat ($urandom_range(1, 8))
				send(OP_TICK, pick_sector(), 1'($urandom_range(1)),
					1'($urandom_range(1)));
		end else if (pick < 93) begin
			send(OP_DISPATCH, pick_sector(), 1'($urandom_range(1)),
				1'($urandom_range(1)));
		end else begin
			send(OP_UNUSED, pick_sector(), 1'($urandom_range(1)),
				1'($urandom_range(1)));
		end
	endtask

	initial begin
		int target;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_BATCH_THRESHOLD;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_ADD;
		req_ch.sector = '0;
		req_ch.is_write = 1'b0;
		req_ch.force_req = 1'b0;
		req_idle_pct = 0;
		rsp_idle_pct = 0;
		hold_requests = 0;
		items_sent = 0;
		hot_base = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(3, 2);
		send(OP_DISPATCH, '0, 1'b0, 1'b1);
		send(OP_UNUSED, SECTOR_TOP, 1'b1, 1'b1);
		send(OP_ADD, '0, 1'b0, 1'b0);
		send(OP_ADD, SECTOR_TOP, 1'b1, 1'b1);
		send(OP_DISPATCH, '0, 1'b0, 1'b0);
		send(OP_TICK, '0, 1'b0, 1'b0);
		send(OP_DISPATCH, '0, 1'b0, 1'b1);
		send(OP_ADD, SB'(100), 1'b1, 1'b0);
		send(OP_ADD, SB'(50), 1'b0, 1'b0);
		send(OP_ADD, SB'(150), 1'b1, 1'b0);
		send(OP_DISPATCH, '0, 1'b0, 1'b0);
		send(OP_ADD, SB'(40), 1'b1, 1'b0);
		send(OP_ADD, SB'(60), 1'b0, 1'b0);
		send(OP_ADD, SB'(50), 1'b1, 1'b0);
		repeat (3) send(OP_TICK, '0, 1'b0, 1'b0);
		send(OP_ADD, SB'(7), 1'b0, 1'b0);
		send(OP_ADD, SB'(9), 1'b1, 1'b0);
		repeat (2) send(OP_TICK, '0, 1'b0, 1'b0);
		configure(3, 1);
		send(OP_DISPATCH, '0, 1'b0, 1'b0);
		send(OP_TICK, '0, 1'b0, 1'b0);
		send(OP_ADD, SB'(5), 1'b0, 1'b0);
		send(OP_DISPATCH, '0, 1'b0, 1'b0);
		repeat (2) send(OP_TICK, '0, 1'b0, 1'b0);

		phase_thr[5] = $urandom_range(1, 64);
		phase_lim[5] = $urandom_range(1, 255);
		for (int p = 0; p < 6; p++) begin
			configure(phase_thr[p], phase_lim[p]);
			if (p < 2) begin
				req_idle_pct = 14;
				rsp_idle_pct = 72;
			end else if (p < 4) begin
				req_idle_pct = 72;
				rsp_idle_pct = 14;
			end else begin
				req_idle_pct = 0;
				rsp_idle_pct = 0;
			end
			if (p == 4) begin
				// fill the store, then stall the response side while further adds are rejected
				send(OP_DISPATCH, '0, 1'b0, 1'b1);
				hot_base = SB'({$urandom, $urandom});
				repeat (QUEUE_DEPTH_DEF)
					send(OP_ADD, pick_sector(), 1'($urandom_range(1)), 1'b0);
				hold_requests <= hold_requests + 1;
				repeat (3) send(OP_ADD, pick_sector(), 1'($urandom_range(1)), 1'b0);
				send(OP_DISPATCH, '0, 1'b0, 1'b1);
				settle();
			end
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target)
				random_burst();
		end

		settle();
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
